[hdl/spgrm_pkg.sv]
// ----------------------------------------------------------------------------
// spgrm_pkg
// Shared widths, mode codes, controller/datapath bundles and pan helpers for
// the stereo pan gain ramp mixer.
// ----------------------------------------------------------------------------
package spgrm_pkg;

  // field widths
  localparam int PAN_W  = 16;
  localparam int VOL_W  = 17;
  localparam int LEN_W  = 13;
  localparam int SMP_W  = 16;
  localparam int ACC_W  = 32;
  localparam int FACT_W = 16;
  localparam int GAIN_W = 17;
  localparam int PROD_W = SMP_W + GAIN_W + 1;

  // longest ramp
  localparam int MAX_BLOCK = 4096;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BLOCK);

  // ramp divider: one quotient bit per step
  localparam int DIV_STEPS = GAIN_W;
  localparam int DIVCNT_W  = $clog2(DIV_STEPS + 1);

  // unity pan factor in Q15
  localparam logic [FACT_W-1:0] FACT_ONE = 16'h8000;

  // item modes
  localparam logic [1:0] MODE_SET   = 2'd0;
  localparam logic [1:0] MODE_BEGIN = 2'd1;
  localparam logic [1:0] MODE_MIX   = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic set_pan;
    logic gain_sel_new;
    logic old_load;
    logic new_load;
    logic div_init;
    logic div_step;
    logic block_commit;
    logic gain_load;
    logic prod_load;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] mode;
    logic       count_zero;
    logic       samples_zero;
    logic       out_free;
  } dp_sts_t;

  // left pan factor: attenuated when panned right
  function automatic logic [FACT_W-1:0] factor_left(input logic signed [PAN_W-1:0] p);
    logic [FACT_W-1:0] f;
    if (!p[PAN_W-1] && (p != '0)) f = FACT_ONE - FACT_W'(p);
    else f = FACT_ONE;
    return f;
  endfunction

  // right pan factor: attenuated when panned left
  function automatic logic [FACT_W-1:0] factor_right(input logic signed [PAN_W-1:0] p);
    logic [FACT_W-1:0] f;
    if (p[PAN_W-1]) f = FACT_ONE + FACT_W'(p);
    else f = FACT_ONE;
    return f;
  endfunction

endpackage

[hdl/stereo_pan_gain_ramp_mixer_top.sv]
// ----------------------------------------------------------------------------
// stereo_pan_gain_ramp_mixer_top
// Mixes a mono sample into a stereo accumulator pair with pan and a linear
// gain ramp; one sequencer drives one datapath.
// ----------------------------------------------------------------------------
// mix item: gain, multiply, add (waits for free output); next item taken after add
// begin-block item: old gains, new gains, 17-step restoring ramp divide, commit
// set item and ignored items: handled at accept, no sequencer steps follow
// a result waiting in the output register does not hold off the next item
// synchronous reset: ramp gains and pan history clear, ramp length is one,
// no block open, output empty
module stereo_pan_gain_ramp_mixer_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           mode,
  input  logic signed [spgrm_pkg::PAN_W-1:0]   pan,
  input  logic [spgrm_pkg::VOL_W-1:0]          volume,
  input  logic [spgrm_pkg::LEN_W-1:0]          block_length,
  input  logic [spgrm_pkg::LEN_W-1:0]          sample_count,
  input  logic signed [spgrm_pkg::SMP_W-1:0]   sample,
  input  logic signed [spgrm_pkg::ACC_W-1:0]   left_in,
  input  logic signed [spgrm_pkg::ACC_W-1:0]   right_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [spgrm_pkg::ACC_W-1:0]   left_out,
  output logic signed [spgrm_pkg::ACC_W-1:0]   right_out,
  output logic                                 last
);
  import spgrm_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  spgrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath
  spgrm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .mode         (mode),
    .pan          (pan),
    .volume       (volume),
    .block_length (block_length),
    .sample_count (sample_count),
    .sample       (sample),
    .left_in      (left_in),
    .right_in     (right_in),
    .left_out     (left_out),
    .right_out    (right_out),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

endmodule

[hdl/spgrm_ctrl.sv]
// ----------------------------------------------------------------------------
// spgrm_ctrl
// Sequencer for the mixer: accepts items, runs the block setup (gains and
// ramp divide) and the per-sample gain, multiply and accumulate steps.
// ----------------------------------------------------------------------------
module spgrm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output spgrm_pkg::dp_cmd_t  cmd,
  input  spgrm_pkg::dp_sts_t  sts
);
  import spgrm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_OLDG, S_NEWG, S_DINIT, S_DIV, S_COMMIT, S_GAIN, S_MUL, S_OUT
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [DIVCNT_W-1:0] div_cnt;
  logic                accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.capture = accept;
        cmd.set_pan = accept && (sts.mode == MODE_SET);
        if (accept && (sts.mode == MODE_BEGIN) && !sts.count_zero) state_next = S_OLDG;
        if (accept && (sts.mode == MODE_MIX) && !sts.samples_zero) state_next = S_GAIN;
      end
      S_OLDG: begin
        cmd.old_load = 1'b1;
        state_next   = S_NEWG;
      end
      S_NEWG: begin
        cmd.gain_sel_new = 1'b1;
        cmd.new_load     = 1'b1;
        state_next       = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DIVCNT_W'(DIV_STEPS - 1)) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.block_commit = 1'b1;
        state_next       = S_IDLE;
      end
      S_GAIN: begin
        cmd.gain_load = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.prod_load = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and divide step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_DINIT) div_cnt <= '0;
      else if (state == S_DIV) div_cnt <= div_cnt + 1'b1;
    end
  end

  // a result is only written into a free output slot
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free) else $error("output overwritten");

  // divide never runs past its step count
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt < DIVCNT_W'(DIV_STEPS))) else $error("divide overrun");

  // a mix item in an open block starts the sample sequence
  a_mix_start: assert property (@(posedge clk) disable iff (rst)
    (accept && (sts.mode == MODE_MIX) && !sts.samples_zero) |=> (state == S_GAIN))
    else $error("mix item dropped");

endmodule

[hdl/spgrm_dp.sv]
// ----------------------------------------------------------------------------
// spgrm_dp
// Datapath: item registers, pan gain multipliers, restoring ramp divider,
// incremental ramp accumulators, sample multiply and output register.
// ----------------------------------------------------------------------------
module spgrm_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  spgrm_pkg::dp_cmd_t                   cmd,
  output spgrm_pkg::dp_sts_t                   sts,
  input  logic [1:0]                           mode,
  input  logic signed [spgrm_pkg::PAN_W-1:0]   pan,
  input  logic [spgrm_pkg::VOL_W-1:0]          volume,
  input  logic [spgrm_pkg::LEN_W-1:0]          block_length,
  input  logic [spgrm_pkg::LEN_W-1:0]          sample_count,
  input  logic signed [spgrm_pkg::SMP_W-1:0]   sample,
  input  logic signed [spgrm_pkg::ACC_W-1:0]   left_in,
  input  logic signed [spgrm_pkg::ACC_W-1:0]   right_in,
  output logic signed [spgrm_pkg::ACC_W-1:0]   left_out,
  output logic signed [spgrm_pkg::ACC_W-1:0]   right_out,
  output logic                                 last,
  output logic                                 out_valid,
  input  logic                                 out_ready
);
  import spgrm_pkg::*;

  // captured item
  logic signed [PAN_W-1:0] it_pan;
  logic [VOL_W-1:0]        it_vol;
  logic [LEN_W-1:0]        it_len;
  logic [LEN_W-1:0]        it_cnt;
  logic signed [SMP_W-1:0] it_smp;
  logic signed [ACC_W-1:0] it_left;
  logic signed [ACC_W-1:0] it_right;
  logic [LEN_W-1:0]        len_clamp;
  logic [LEN_W-1:0]        cnt_clamp;

  // pan and volume history
  logic signed [PAN_W-1:0] last_pan;
  logic [VOL_W-1:0]        last_vol;

  // block setup
  logic [GAIN_W-1:0]       g_old_l, g_old_r, g_new_l, g_new_r;
  logic [2*FACT_W:0]       mul_l, mul_r;
  logic signed [PAN_W-1:0] mpan;
  logic [VOL_W-1:0]        mvol;
  logic signed [GAIN_W:0]  delta_l, delta_r;
  logic                    div_neg_l, div_neg_r;
  logic [GAIN_W-1:0]       div_q_l, div_q_r;
  logic [LEN_W-1:0]        div_rem_l, div_rem_r;
  logic [LEN_W:0]          trial_l, trial_r;
  logic                    ge_l, ge_r;

  // ramp state
  logic [GAIN_W-1:0]       start_l, start_r;
  logic                    neg_l, neg_r;
  logic [GAIN_W-1:0]       step_q_l, step_q_r;
  logic [LEN_W-1:0]        step_r_l, step_r_r;
  logic [GAIN_W-1:0]       acc_q_l, acc_q_r;
  logic [LEN_W-1:0]        acc_r_l, acc_r_r;
  logic [LEN_W:0]          rsum_l, rsum_r;
  logic                    wrap_l, wrap_r;
  logic [LEN_W-1:0]        ramp_len;
  logic [LEN_W-1:0]        samples_left;

  // per sample
  logic signed [GAIN_W:0]   gain_l, gain_r;
  logic signed [PROD_W-1:0] prod_l, prod_r;
  logic signed [ACC_W-1:0]  add_l, add_r;

  // length and count saturation
  always_comb begin
    if (block_length == '0) len_clamp = LEN_W'(1);
    else if (block_length > MAX_LEN) len_clamp = MAX_LEN;
    else len_clamp = block_length;
    cnt_clamp = (sample_count > len_clamp) ? len_clamp : sample_count;
  end

  // status
  assign sts.mode         = mode;
  assign sts.count_zero   = (sample_count == '0);
  assign sts.samples_zero = (samples_left == '0);
  assign sts.out_free     = !out_valid || out_ready;

  // pan gain multipliers, old or new pan/volume
  assign mpan  = cmd.gain_sel_new ? it_pan : last_pan;
  assign mvol  = cmd.gain_sel_new ? it_vol : last_vol;
  assign mul_l = (2*FACT_W+1)'(factor_left(mpan)) * (2*FACT_W+1)'(mvol);
  assign mul_r = (2*FACT_W+1)'(factor_right(mpan)) * (2*FACT_W+1)'(mvol);

  // gain change and divider step
  assign delta_l = $signed({1'b0, g_new_l}) - $signed({1'b0, g_old_l});
  assign delta_r = $signed({1'b0, g_new_r}) - $signed({1'b0, g_old_r});
  assign trial_l = {div_rem_l, div_q_l[GAIN_W-1]};
  assign trial_r = {div_rem_r, div_q_r[GAIN_W-1]};
  assign ge_l    = (trial_l >= {1'b0, it_len});
  assign ge_r    = (trial_r >= {1'b0, it_len});

  // ramp remainder step
  assign rsum_l = {1'b0, acc_r_l} + {1'b0, step_r_l};
  assign rsum_r = {1'b0, acc_r_r} + {1'b0, step_r_r};
  assign wrap_l = (rsum_l >= {1'b0, ramp_len});
  assign wrap_r = (rsum_r >= {1'b0, ramp_len});

  // scaled sample, floor of product over 65536
  assign add_l = ACC_W'(prod_l >>> 16);
  assign add_r = ACC_W'(prod_r >>> 16);

  // item capture and setup registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_pan   <= pan;
      it_vol   <= volume;
      it_len   <= len_clamp;
      it_cnt   <= cnt_clamp;
      it_smp   <= sample;
      it_left  <= left_in;
      it_right <= right_in;
    end
    if (cmd.old_load) begin
      g_old_l <= mul_l[2*FACT_W-1:FACT_W-1];
      g_old_r <= mul_r[2*FACT_W-1:FACT_W-1];
    end
    if (cmd.new_load) begin
      g_new_l <= mul_l[2*FACT_W-1:FACT_W-1];
      g_new_r <= mul_r[2*FACT_W-1:FACT_W-1];
    end
    if (cmd.div_init) begin
      div_neg_l <= delta_l[GAIN_W];
      div_neg_r <= delta_r[GAIN_W];
      div_q_l   <= delta_l[GAIN_W] ? GAIN_W'(-delta_l) : GAIN_W'(delta_l);
      div_q_r   <= delta_r[GAIN_W] ? GAIN_W'(-delta_r) : GAIN_W'(delta_r);
      div_rem_l <= '0;
      div_rem_r <= '0;
    end else if (cmd.div_step) begin
      div_q_l   <= {div_q_l[GAIN_W-2:0], ge_l};
      div_q_r   <= {div_q_r[GAIN_W-2:0], ge_r};
      div_rem_l <= ge_l ? LEN_W'(trial_l - {1'b0, it_len}) : LEN_W'(trial_l);
      div_rem_r <= ge_r ? LEN_W'(trial_r - {1'b0, it_len}) : LEN_W'(trial_r);
    end
    if (cmd.gain_load) begin
      gain_l <= neg_l ? $signed({1'b0, start_l}) - $signed({1'b0, acc_q_l})
                      : $signed({1'b0, start_l}) + $signed({1'b0, acc_q_l});
      gain_r <= neg_r ? $signed({1'b0, start_r}) - $signed({1'b0, acc_q_r})
                      : $signed({1'b0, start_r}) + $signed({1'b0, acc_q_r});
    end
    if (cmd.prod_load) begin
      prod_l <= PROD_W'(it_smp) * PROD_W'(gain_l);
      prod_r <= PROD_W'(it_smp) * PROD_W'(gain_r);
    end
    if (cmd.out_load) begin
      left_out  <= it_left + add_l;
      right_out <= it_right + add_r;
      last      <= (samples_left == LEN_W'(1));
    end
  end

  // block state, ramp accumulators and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pan     <= '0;
      last_vol     <= '0;
      start_l      <= '0;
      start_r      <= '0;
      neg_l        <= 1'b0;
      neg_r        <= 1'b0;
      step_q_l     <= '0;
      step_q_r     <= '0;
      step_r_l     <= '0;
      step_r_r     <= '0;
      acc_q_l      <= '0;
      acc_q_r      <= '0;
      acc_r_l      <= '0;
      acc_r_r      <= '0;
      ramp_len     <= LEN_W'(1);
      samples_left <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.set_pan) begin
        last_pan <= pan;
        last_vol <= volume;
      end
      if (cmd.block_commit) begin
        last_pan     <= it_pan;
        last_vol     <= it_vol;
        start_l      <= g_old_l;
        start_r      <= g_old_r;
        neg_l        <= div_neg_l;
        neg_r        <= div_neg_r;
        step_q_l     <= div_q_l;
        step_q_r     <= div_q_r;
        step_r_l     <= div_rem_l;
        step_r_r     <= div_rem_r;
        acc_q_l      <= '0;
        acc_q_r      <= '0;
        acc_r_l      <= '0;
        acc_r_r      <= '0;
        ramp_len     <= it_len;
        samples_left <= it_cnt;
      end
      if (cmd.out_load) begin
        samples_left <= samples_left - 1'b1;
        acc_q_l <= acc_q_l + step_q_l + GAIN_W'(wrap_l);
        acc_q_r <= acc_q_r + step_q_r + GAIN_W'(wrap_r);
        acc_r_l <= wrap_l ? LEN_W'(rsum_l - {1'b0, ramp_len}) : LEN_W'(rsum_l);
        acc_r_r <= wrap_r ? LEN_W'(rsum_r - {1'b0, ramp_len}) : LEN_W'(rsum_r);
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // every mixed sample consumes one count of the block
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (samples_left == $past(samples_left) - LEN_W'(1)))
    else $error("sample count not decremented");

  // ramp remainder stays below the ramp length
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    !cmd.block_commit |=> (acc_r_l < ramp_len) && (acc_r_r < ramp_len))
    else $error("ramp remainder out of range");

  // a waiting result holds until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(left_out) &&
                                  $stable(right_out) && $stable(last))
    else $error("result changed before accept");

endmodule

[sim/tb_stereo_pan_gain_ramp_mixer_top.sv]
// ----------------------------------------------------------------------------
// tb_stereo_pan_gain_ramp_mixer_top
// Self-checking bench for the stereo pan gain ramp mixer. A bit-exact
// predictor follows every accepted item and queues the mixed accumulator
// pair it should produce. Directed items cover the field extremes, ignored
// items, count and length clamping, block reopening and steady gains. Random
// traffic then runs mostly well-formed blocks with some noise mixed in. The
// sender idles in bursts and the receiver stalls in windows of random duty.
// ----------------------------------------------------------------------------
module tb_stereo_pan_gain_ramp_mixer_top;
  import spgrm_pkg::*;

  // the one item mode the package leaves unnamed
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1750;

  typedef struct {
    logic [ACC_W-1:0] lsum;
    logic [ACC_W-1:0] rsum;
    logic             is_last;
  } mix_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               mode = MODE_SET;
  logic signed [PAN_W-1:0]  pan = '0;
  logic [VOL_W-1:0]         volume = '0;
  logic [LEN_W-1:0]         block_length = '0;
  logic [LEN_W-1:0]         sample_count = '0;
  logic signed [SMP_W-1:0]  sample = '0;
  logic signed [ACC_W-1:0]  left_in = '0;
  logic signed [ACC_W-1:0]  right_in = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [ACC_W-1:0]  left_out;
  logic signed [ACC_W-1:0]  right_out;
  logic                     last;

  // predicted mixer state
  logic signed [PAN_W-1:0]  hist_pan = '0;
  logic [VOL_W-1:0]         hist_vol = '0;
  longint                   lg_start = 0;
  longint                   rg_start = 0;
  longint                   lg_delta = 0;
  longint                   rg_delta = 0;
  int unsigned              ramp_len = 1;
  int unsigned              ramp_idx = 0;
  int unsigned              remaining = 0;

  mix_result_t              pending_mix[$];

  int errors = 0;
  int items_sent = 0;
  int items_used = 0;
  int blocks_opened = 0;
  int results_checked = 0;
  int burst_left = 0;
  bit gaps_enabled = 1'b1;
  int stall_win = 0;
  int stall_pct = 0;

  stereo_pan_gain_ramp_mixer_top i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .pan(pan),
    .volume(volume),
    .block_length(block_length),
    .sample_count(sample_count),
    .sample(sample),
    .left_in(left_in),
    .right_in(right_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .left_out(left_out),
    .right_out(right_out),
    .last(last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout at %0t with %0d results outstanding", $time, pending_mix.size());
    $display("tb_stereo_pan_gain_ramp_mixer_top NOT OK");
    $finish;
  end

  // gain of one side: pan factor in Q15 times volume, back to Q16
  function automatic longint pan_gain(input logic signed [PAN_W-1:0] p,
                                      input logic [VOL_W-1:0] v, input bit right_side);
    longint f;
    if (!right_side) f = (p > 0) ? 32768 - p : 32768;
    else f = (p < 0) ? 32768 + p : 32768;
    return (f * longint'(v)) / 32768;
  endfunction

  // accumulator plus floor(sample * gain / 2^16), wrapping at 32 bits
  function automatic logic [ACC_W-1:0] add_scaled(input logic [ACC_W-1:0] acc,
                                                  input logic signed [SMP_W-1:0] s,
                                                  input longint g);
    longint prod;
    prod = longint'(s) * g;
    return acc + ACC_W'(prod >>> 16);
  endfunction

  // advance the predicted state by one item; returns 1 unless the item is ignored
  function automatic bit predict_mix(input logic [1:0] m, input logic signed [PAN_W-1:0] p,
                                     input logic [VOL_W-1:0] v, input logic [LEN_W-1:0] blen,
                                     input logic [LEN_W-1:0] scnt,
                                     input logic signed [SMP_W-1:0] s,
                                     input logic [ACC_W-1:0] l, input logic [ACC_W-1:0] r);
    int unsigned len;
    int unsigned cnt;
    longint lg;
    longint rg;
    mix_result_t res;
    predict_mix = 1'b0;
    case (m)
      MODE_SET: begin
        hist_pan = p;
        hist_vol = v;
        predict_mix = 1'b1;
      end
      MODE_BEGIN: begin
        len = blen;
        cnt = scnt;
        if (cnt != 0) begin
          if (len == 0) len = 1;
          if (len > MAX_BLOCK) len = MAX_BLOCK;
          if (cnt > len) cnt = len;
          lg_start = pan_gain(hist_pan, hist_vol, 1'b0);
          rg_start = pan_gain(hist_pan, hist_vol, 1'b1);
          lg_delta = pan_gain(p, v, 1'b0) - lg_start;
          rg_delta = pan_gain(p, v, 1'b1) - rg_start;
          ramp_len = len;
          ramp_idx = 0;
          remaining = cnt;
          hist_pan = p;
          hist_vol = v;
          blocks_opened++;
          predict_mix = 1'b1;
        end
      end
      MODE_MIX: begin
        if (remaining != 0) begin
          lg = lg_start + (lg_delta * longint'(ramp_idx)) / longint'(ramp_len);
          rg = rg_start + (rg_delta * longint'(ramp_idx)) / longint'(ramp_len);
          res.lsum = add_scaled(l, s, lg);
          res.rsum = add_scaled(r, s, rg);
          res.is_last = (remaining == 1);
          pending_mix.push_back(res);
          remaining--;
          ramp_idx++;
          predict_mix = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // random field values, leaning on the extremes now and then
  function automatic logic signed [PAN_W-1:0] rand_pan();
    logic signed [PAN_W-1:0] edges[5] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001};
    if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 4)];
    return PAN_W'($urandom);
  endfunction

  function automatic logic [VOL_W-1:0] rand_vol();
    logic [VOL_W-1:0] edges[4] = '{17'd0, 17'd65536, 17'h1ffff, 17'd1};
    if ($urandom_range(0, 4) == 0) return edges[$urandom_range(0, 3)];
    return VOL_W'($urandom_range(0, 131071));
  endfunction

  function automatic logic signed [SMP_W-1:0] rand_sample();
    logic signed [SMP_W-1:0] edges[4] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
    if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 3)];
    return SMP_W'($urandom);
  endfunction

  function automatic logic [ACC_W-1:0] rand_acc();
    logic [ACC_W-1:0] edges[4] = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff};
    if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // drive one item, hold it until accepted, then update the prediction
  task automatic send_item(input logic [1:0] m, input logic signed [PAN_W-1:0] p,
                           input logic [VOL_W-1:0] v, input logic [LEN_W-1:0] blen,
                           input logic [LEN_W-1:0] scnt, input logic signed [SMP_W-1:0] s,
                           input logic [ACC_W-1:0] l, input logic [ACC_W-1:0] r);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_enabled && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 25);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    pan <= p;
    volume <= v;
    block_length <= blen;
    sample_count <= scnt;
    sample <= s;
    left_in <= l;
    right_in <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (predict_mix(m, p, v, blen, scnt, s, l, r)) items_used++;
  endtask

  // one sample item with random audio and accumulators
  task automatic send_sample();
    send_item(MODE_MIX, rand_pan(), rand_vol(), LEN_W'($urandom), LEN_W'($urandom),
              rand_sample(), rand_acc(), rand_acc());
  endtask

  // any mode, any field value
  task automatic send_noise();
    logic [LEN_W-1:0] cnt;
    cnt = ($urandom_range(0, 3) == 0) ? '0 : LEN_W'($urandom);
    send_item(2'($urandom), PAN_W'($urandom), VOL_W'($urandom_range(0, 131071)),
              LEN_W'($urandom), cnt, SMP_W'($urandom), $urandom, $urandom);
  endtask

  // items that must give nothing, and a zero count that keeps the pan history
  task automatic test_ignored_items();
    send_sample();
    send_item(MODE_UNUSED, rand_pan(), rand_vol(), 13'd5, 13'd5, rand_sample(),
              rand_acc(), rand_acc());
    send_item(MODE_SET, 16'sh4000, 17'd65536, '0, '0, '0, '0, '0);
    send_item(MODE_BEGIN, 16'sh9000, 17'd12345, 13'd8, 13'd0, '0, '0, '0);
    send_item(MODE_BEGIN, 16'shc000, 17'd30000, 13'd1, 13'd1, '0, '0, '0);
    send_sample();
  endtask

  // field extremes, zero length and saturating length
  task automatic test_field_extremes();
    send_item(MODE_SET, 16'sh8000, 17'd65536, '0, '0, '0, '0, '0);
    send_item(MODE_BEGIN, 16'sh7fff, 17'h1ffff, 13'd0, 13'd1, '0, '0, '0);
    send_item(MODE_MIX, '0, '0, '0, '0, 16'sh8000, 32'h7fffffff, 32'h80000000);
    send_item(MODE_BEGIN, 16'sh0000, 17'd0, 13'h1fff, 13'd2, '0, '0, '0);
    send_item(MODE_MIX, '0, '0, '0, '0, 16'sh7fff, 32'h80000000, 32'h7fffffff);
    send_item(MODE_MIX, '0, '0, '0, '0, 16'sh8000, 32'h0, 32'hffffffff);
  endtask

  // open a block with count above length, then mix past its end
  task automatic test_reopen_and_clamp();
    send_item(MODE_BEGIN, 16'shffff, 17'd65536, 13'd3, 13'h1fff, '0, '0, '0);
    repeat (4) send_sample();
  endtask

  // constant ramps, including both gains at zero
  task automatic test_steady_gain();
    send_item(MODE_SET, 16'sh0000, 17'd0, '0, '0, '0, '0, '0);
    send_item(MODE_BEGIN, 16'sh0000, 17'd0, 13'd4, 13'd2, '0, '0, '0);
    repeat (2) send_sample();
    send_item(MODE_SET, 16'sd12345, 17'd40000, '0, '0, '0, '0, '0);
    send_item(MODE_BEGIN, 16'sd12345, 17'd40000, 13'd2, 13'd2, '0, '0, '0);
    repeat (2) send_sample();
  endtask

  // mostly well-formed blocks with random content, some noise and broken blocks
  task automatic test_random_traffic();
    int unsigned blen;
    int unsigned len_eff;
    int unsigned cnt;
    int unsigned n;
    int pick;
    while (items_used < RANDOM_ITEMS) begin
      // a stretch with no sender gaps
      gaps_enabled = !(items_used >= 900 && items_used < 1100);
      if ($urandom_range(0, 99) < 15) begin
        send_noise();
      end else begin
        if ($urandom_range(0, 1) == 1)
          send_item(MODE_SET, rand_pan(), rand_vol(), LEN_W'($urandom), LEN_W'($urandom),
                    rand_sample(), rand_acc(), rand_acc());
        pick = $urandom_range(0, 99);
        if (pick < 85) blen = $urandom_range(1, 16);
        else if (pick < 93) blen = $urandom_range(17, 300);
        else if (pick < 97) blen = 0;
        else blen = ($urandom_range(0, 1) == 1) ? MAX_BLOCK : $urandom_range(4097, 8191);
        len_eff = (blen == 0) ? 1 : (blen > MAX_BLOCK) ? MAX_BLOCK : blen;
        pick = $urandom_range(0, 9);
        if (blen >= MAX_BLOCK) cnt = $urandom_range(1, 40);
        else if (pick < 8) cnt = $urandom_range(1, len_eff);
        else if (pick == 8) cnt = len_eff;
        else cnt = $urandom_range(len_eff + 1, 8191);
        send_item(MODE_BEGIN, rand_pan(), rand_vol(), LEN_W'(blen), LEN_W'(cnt),
                  rand_sample(), rand_acc(), rand_acc());
        n = (cnt > len_eff) ? len_eff : cnt;
        pick = $urandom_range(0, 99);
        if (pick < 10) n = $urandom_range(0, n - 1);
        else if (pick < 15) n = n + $urandom_range(1, 3);
        repeat (n) begin
          if ($urandom_range(0, 99) < 5) send_noise();
          send_sample();
        end
      end
    end
    gaps_enabled = 1'b1;
  endtask

  // result check and receiver stall pattern
  always @(posedge clk) begin : rx
    mix_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_mix.size() == 0) begin
        $display("%0t: result with nothing expected: left_out %h right_out %h last %b",
                 $time, left_out, right_out, last);
        errors++;
      end else begin
        want = pending_mix.pop_front();
        results_checked++;
        if (left_out !== want.lsum) begin
          $display("%0t: left_out expected %h actual %h", $time, want.lsum, left_out);
          errors++;
        end
        if (right_out !== want.rsum) begin
          $display("%0t: right_out expected %h actual %h", $time, want.rsum, right_out);
          errors++;
        end
        if (last !== want.is_last) begin
          $display("%0t: last expected %b actual %b", $time, want.is_last, last);
          errors++;
        end
      end
    end
    // windows of random duty, some with no stall at all
    if (stall_win == 0) begin
      stall_win = $urandom_range(32, 128);
      stall_pct = 25 * $urandom_range(0, 3);
    end
    stall_win--;
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_ignored_items();
    test_field_extremes();
    test_reopen_and_clamp();
    test_steady_gain();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d items (%0d not ignored), opened %0d blocks", items_sent, items_used,
             blocks_opened);
    $display("checked %0d mixed results, %0d mismatches", results_checked, errors);
    if (errors == 0 && pending_mix.size() == 0) begin
      $display("tb_stereo_pan_gain_ramp_mixer_top OK");
    end else begin
      $display("tb_stereo_pan_gain_ramp_mixer_top NOT OK");
    end
    $finish;
  end

endmodule
